// ----- src/euler_xyz_point_rotator_defines.svh -----
// Assertion macros shared by the checker of the Euler XYZ point rotator.
// No dependencies; included by the files that assert.
`ifndef EULER_XYZ_POINT_ROTATOR_DEFINES_SVH
`define EULER_XYZ_POINT_ROTATOR_DEFINES_SVH

// Clocked property, masked while reset is asserted
`define EULR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds during reset
`define EULR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- src/eulr_pkg.sv -----
// Shared widths, types, sine table and arithmetic helpers for the Euler XYZ
// point rotator. No dependencies.
package eulr_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2;
    localparam int PROD_WIDTH     = COORD_WIDTH + TRIG_WIDTH;
    localparam int SUM_WIDTH      = PROD_WIDTH + 1;
    localparam int ANGLE_WIDTH    = 9;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam int DEG_PER_TURN   = 360;
    localparam int QUARTER_DEG    = 90;
    localparam int HALF_DEG       = 180;
    localparam int THREE_Q_DEG    = 270;
    localparam int QTR_IDX_WIDTH  = $clog2(QUARTER_DEG + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ANGLE_X = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ANGLE_Y = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ANGLE_Z = CFG_IDX_WIDTH'(2);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [TRIG_WIDTH-1:0]  t_trig;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;
    typedef logic [ANGLE_WIDTH-1:0]        t_angle;
    typedef logic [CFG_IDX_WIDTH-1:0]      t_cfg_idx;
    typedef logic [TRIG_FRAC_BITS:0]       t_qsin;
    typedef logic [QUARTER_DEG:0][TRIG_FRAC_BITS:0] t_sin_rom;

    typedef struct packed {
        t_trig sin_v;
        t_trig cos_v;
    } t_trig_pair;

    localparam t_trig  TRIG_ONE  = t_trig'(TRIG_WIDTH'(1) << TRIG_FRAC_BITS);
    localparam t_trig  TRIG_ZERO = t_trig'(0);
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Sine of 0..90 degrees: Q30 Taylor series, rounded half up to the table format
    function automatic logic [63:0] quarter_sine(input int unsigned deg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        term = ((term * x2) >> 30) / 64'd6;   acc = acc - term;
        term = ((term * x2) >> 30) / 64'd20;  acc = acc + term;
        term = ((term * x2) >> 30) / 64'd42;  acc = acc - term;
        term = ((term * x2) >> 30) / 64'd72;  acc = acc + term;
        term = ((term * x2) >> 30) / 64'd110; acc = acc - term;
        term = ((term * x2) >> 30) / 64'd156; acc = acc + term;
        term = ((term * x2) >> 30) / 64'd210; acc = acc - term;
        term = ((term * x2) >> 30) / 64'd272; acc = acc + term;
        return (acc + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    endfunction

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            rom[d] = t_qsin'(quarter_sine(d));
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

    // Fold an angle of 360..511 back into one turn
    function automatic t_angle angle_reduce(input t_angle a);
        return (a >= ANGLE_WIDTH'(DEG_PER_TURN)) ? t_angle'(a - ANGLE_WIDTH'(DEG_PER_TURN)) : a;
    endfunction

    // Signed sine of a reduced angle from the quarter-wave table
    function automatic t_trig sin_lookup(input t_angle a);
        t_angle folded;
        logic   neg;
        t_qsin  mag;
        if (a <= ANGLE_WIDTH'(QUARTER_DEG)) begin
            folded = a;
            neg    = 1'b0;
        end else if (a <= ANGLE_WIDTH'(HALF_DEG)) begin
            folded = t_angle'(ANGLE_WIDTH'(HALF_DEG) - a);
            neg    = 1'b0;
        end else if (a <= ANGLE_WIDTH'(THREE_Q_DEG)) begin
            folded = t_angle'(a - ANGLE_WIDTH'(HALF_DEG));
            neg    = 1'b1;
        end else begin
            folded = t_angle'(ANGLE_WIDTH'(DEG_PER_TURN) - a);
            neg    = 1'b1;
        end
        mag = SIN_ROM[folded[QTR_IDX_WIDTH-1:0]];
        return neg ? -t_trig'({1'b0, mag}) : t_trig'({1'b0, mag});
    endfunction

    // Round half up to coordinate format and clamp to the coordinate range
    function automatic t_coord round_sat(input t_sum s);
        t_sum v;
        t_sum q;
        v = s + t_sum'(SUM_WIDTH'(1) << (TRIG_FRAC_BITS - 1));
        q = v >>> TRIG_FRAC_BITS;
        if (q > t_sum'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (q < t_sum'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return t_coord'(q);
    endfunction

endpackage

// ----- src/eulr_if.sv -----
// Stream and configuration interfaces of the Euler XYZ point rotator.
// Depends on eulr_pkg.
interface eulr_in_if;
    import eulr_pkg::*;
    logic   valid;
    logic   ready;
    t_coord x_in;
    t_coord y_in;
    t_coord z_in;
    modport source (output valid, x_in, y_in, z_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface eulr_out_if;
    import eulr_pkg::*;
    logic   valid;
    logic   ready;
    t_coord x_out;
    t_coord y_out;
    t_coord z_out;
    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

interface eulr_cfg_if;
    import eulr_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_angle   wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/eulr_trig.sv -----
// Angle registers of the rotator, held as sine/cosine pairs per axis.
// Depends on eulr_pkg and eulr_cfg_if.
module eulr_trig (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    eulr_cfg_if.sink              i_cfg,
    output eulr_pkg::t_trig_pair  o_trig_x,
    output eulr_pkg::t_trig_pair  o_trig_y,
    output eulr_pkg::t_trig_pair  o_trig_z
);
    import eulr_pkg::*;

    t_trig_pair r_trig_x, r_trig_y, r_trig_z;
    t_trig_pair n_pair;
    t_angle     ang_s;
    t_angle     ang_c;

    // Always take a configuration beat
    assign i_cfg.ready = 1'b1;

    // Reduce the written angle and look up sine and cosine
    always_comb begin
        ang_s        = angle_reduce(i_cfg.wdata);
        ang_c        = angle_reduce(t_angle'(ang_s + ANGLE_WIDTH'(QUARTER_DEG)));
        n_pair.sin_v = sin_lookup(ang_s);
        n_pair.cos_v = sin_lookup(ang_c);
    end

    // Store the pair of the addressed axis; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_x <= '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE};
            r_trig_y <= '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE};
            r_trig_z <= '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ANGLE_X: r_trig_x <= n_pair;
                CFG_ANGLE_Y: r_trig_y <= n_pair;
                CFG_ANGLE_Z: r_trig_z <= n_pair;
                default: ;
            endcase
        end
    end

    assign o_trig_x = r_trig_x;
    assign o_trig_y = r_trig_y;
    assign o_trig_z = r_trig_z;

endmodule

// ----- src/eulr_plane_rot.sv -----
// Two-stage plane rotation: a' = a c - b s, b' = a s + b c, third axis carried.
// Depends on eulr_pkg.
module eulr_plane_rot (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  eulr_pkg::t_trig_pair  i_trig,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  eulr_pkg::t_coord      i_a,
    input  eulr_pkg::t_coord      i_b,
    input  eulr_pkg::t_coord      i_p,
    output logic                  o_valid,
    input  logic                  i_ready,
    output eulr_pkg::t_coord      o_a,
    output eulr_pkg::t_coord      o_b,
    output eulr_pkg::t_coord      o_p
);
    import eulr_pkg::*;

    logic   r_v1, r_v2;
    t_prod  r_p_ac, r_p_bs, r_p_as, r_p_bc;
    t_coord r_p1;
    t_coord r_a2, r_b2, r_p2;
    logic   adv1, adv2;

    // Each stage moves when it is empty or its successor moves
    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p_ac <= t_prod'(i_a) * t_prod'(i_trig.cos_v);
            r_p_bs <= t_prod'(i_b) * t_prod'(i_trig.sin_v);
            r_p_as <= t_prod'(i_a) * t_prod'(i_trig.sin_v);
            r_p_bc <= t_prod'(i_b) * t_prod'(i_trig.cos_v);
            r_p1   <= i_p;
        end
    end

    // Sum, round and saturate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_a2 <= round_sat(t_sum'(r_p_ac) - t_sum'(r_p_bs));
            r_b2 <= round_sat(t_sum'(r_p_as) + t_sum'(r_p_bc));
            r_p2 <= r_p1;
        end
    end

    assign o_valid = r_v2;
    assign o_a     = r_a2;
    assign o_b     = r_b2;
    assign o_p     = r_p2;

endmodule

// ----- src/euler_xyz_point_rotator.sv -----
// Top level of the Euler XYZ point rotator: angle registers and three plane stages.
// Depends on eulr_pkg, eulr_if, eulr_trig and eulr_plane_rot.
//
//  channel  dir  handshake      payload
//  i_pt     in   valid/ready    x_in, y_in, z_in   (signed Q12.12)
//  o_pt     out  valid/ready    x_out, y_out, z_out (signed Q12.12, saturated)
//  i_cfg    in   valid/ready    index, wdata       (angles in degrees)
//
// One point per cycle while the output takes beats; a point passes through
// two register stages (products, then round/saturate) for each of the X, Y, Z
// rotations. Synchronous active-low reset clears the valid bits and sets all
// angles to zero. A stalled output holds the last stage; earlier stages keep
// filling their empty slots, so input beats continue until every stage is full.
module euler_xyz_point_rotator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eulr_in_if.sink    i_pt,
    eulr_out_if.source o_pt,
    eulr_cfg_if.sink   i_cfg
);
    import eulr_pkg::*;

    t_trig_pair trig_x, trig_y, trig_z;
    logic   v_x, v_y, rdy_x, rdy_y, rdy_z;
    t_coord x1, y1, z1;
    t_coord x2, y2, z2;

    eulr_trig u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_trig_x (trig_x),
        .o_trig_y (trig_y),
        .o_trig_z (trig_z)
    );

    // Rotate about X: plane (y, z)
    eulr_plane_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (trig_x),
        .i_valid (i_pt.valid),
        .o_ready (rdy_x),
        .i_a     (i_pt.y_in),
        .i_b     (i_pt.z_in),
        .i_p     (i_pt.x_in),
        .o_valid (v_x),
        .i_ready (rdy_y),
        .o_a     (y1),
        .o_b     (z1),
        .o_p     (x1)
    );

    // Rotate about Y: plane (z, x)
    eulr_plane_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (trig_y),
        .i_valid (v_x),
        .o_ready (rdy_y),
        .i_a     (z1),
        .i_b     (x1),
        .i_p     (y1),
        .o_valid (v_y),
        .i_ready (rdy_z),
        .o_a     (z2),
        .o_b     (x2),
        .o_p     (y2)
    );

    // Rotate about Z: plane (x, y), last stage drives the output beat
    eulr_plane_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (trig_z),
        .i_valid (v_y),
        .o_ready (rdy_z),
        .i_a     (x2),
        .i_b     (y2),
        .i_p     (z2),
        .o_valid (o_pt.valid),
        .i_ready (o_pt.ready),
        .o_a     (o_pt.x_out),
        .o_b     (o_pt.y_out),
        .o_p     (o_pt.z_out)
    );

    assign i_pt.ready = rdy_x;

endmodule

// ----- src/eulr_checker.sv -----
// Port-level checker for the Euler XYZ point rotator, bound to the top level.
// Depends on eulr_pkg and euler_xyz_point_rotator_defines.svh.
`include "euler_xyz_point_rotator_defines.svh"

module eulr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input eulr_pkg::t_coord i_x_out,
    input eulr_pkg::t_coord i_y_out,
    input eulr_pkg::t_coord i_z_out,
    input logic             i_cfg_ready
);
    import eulr_pkg::*;

    // Reset empties the pipeline, so no output beat right after it
    `EULR_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Input back-pressure only when the whole pipeline is full and stalled
    `EULR_ASSERT(a_ready_full, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !i_out_ready, "input stalled without output stall")

    // A stalled output beat holds its point
    `EULR_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_x_out) && $stable(i_y_out) && $stable(i_z_out), "stalled output changed")

    // Configuration beats are never refused
    `EULR_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_ready && !i_in_valid || i_cfg_ready, "configuration port not ready")

endmodule

bind euler_xyz_point_rotator eulr_checker u_eulr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_x_out     (o_pt.x_out),
    .i_y_out     (o_pt.y_out),
    .i_z_out     (o_pt.z_out),
    .i_cfg_ready (i_cfg.ready)
);

// ----- sim/euler_xyz_point_rotator_test.sv -----
// Self-checking testbench for euler_xyz_point_rotator: drives points and angle
// writes, predicts each rotated point in fixed point and checks every output beat.
// Depends on eulr_pkg, eulr_if and the rotator RTL.
module euler_xyz_point_rotator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import eulr_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 11;
    localparam int SETTLE_CYCLES    = 12;
    localparam int DRAIN_CYCLES     = 24;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int RANDOM_PHASES    = 12;
    localparam int POINTS_PER_PHASE = 145;
    localparam int TIMEOUT_CYCLES   = 400000;

    // Index past the three angle registers; writes to it must be dropped
    localparam t_cfg_idx CFG_SPARE_INDEX = t_cfg_idx'(3);
    // pi in Q2.30, for the quarter-wave sine series
    localparam longint unsigned PI_FIXED_Q30 = 64'd3373259426;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } xyz_point_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    eulr_in_if  pt_in ();
    eulr_out_if pt_out ();
    eulr_cfg_if angle_cfg ();

    euler_xyz_point_rotator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_in),
        .o_pt    (pt_out),
        .i_cfg   (angle_cfg)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: sine table and the angle registers as last written
    int         sine_table [0:QUARTER_DEG];
    t_angle     angle_x_now;
    t_angle     angle_y_now;
    t_angle     angle_z_now;
    xyz_point_t pending_points [$];
    xyz_point_t rotated_points [$];

    // Handshake pulses seen at the last rising edge
    logic pt_beat;
    logic cfg_beat;

    int points_queued;
    int points_checked;
    int angle_writes;
    int clamped_results;
    int failures;

    // Traffic knobs, changed between phases
    int          max_gap;
    int          max_burst;
    logic [15:0] ready_pattern;
    int          stall_requested;

    // Driver and receiver private state
    int         gap_left;
    int         burst_left;
    bit         offer_live;
    xyz_point_t next_point;
    int         stall_served;
    int         hold_left;

    // Sine of 0..90 degrees in Q(TRIG_FRAC_BITS): Q30 Taylor series, rounded half up
    function automatic int quarter_sine_q(input int deg);
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned term;
        longint unsigned acc;
        rad    = (64'(deg) * PI_FIXED_Q30 + 64'd90) / 64'd180;
        rad_sq = (rad * rad) >> 30;
        term   = rad;
        acc    = rad;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        return int'((acc + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
    endfunction

    // Signed sine of any whole-degree angle, folded onto the quarter wave
    function automatic longint sine_of(input int deg);
        int a;
        a = deg % DEG_PER_TURN;
        if (a <= QUARTER_DEG) begin
            return sine_table[a];
        end else if (a <= HALF_DEG) begin
            return sine_table[HALF_DEG - a];
        end else if (a <= THREE_Q_DEG) begin
            return -sine_table[a - HALF_DEG];
        end
        return -sine_table[DEG_PER_TURN - a];
    endfunction

    // Round half toward plus infinity to Q12.12, then clamp to the coordinate range
    function automatic longint round_clamp(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        if (q > longint'(COORD_MAX)) begin
            q = longint'(COORD_MAX);
        end else if (q < longint'(COORD_MIN)) begin
            q = longint'(COORD_MIN);
        end
        return q;
    endfunction

    // a' = a c - b s, b' = a s + b c; a zero angle leaves the plane alone
    function automatic void turn_plane(inout longint a, inout longint b, input t_angle angle);
        int     deg;
        longint s;
        longint c;
        longint na;
        deg = int'(angle) % DEG_PER_TURN;
        if (deg == 0) begin
            return;
        end
        s  = sine_of(deg);
        c  = sine_of(deg + QUARTER_DEG);
        na = round_clamp(a * c - b * s);
        b  = round_clamp(a * s + b * c);
        a  = na;
    endfunction

    // Rotate about X, then Y, then Z with the current angles
    function automatic xyz_point_t predict_rotation(input xyz_point_t p);
        longint px;
        longint py;
        longint pz;
        xyz_point_t r;
        px = longint'(p.x);
        py = longint'(p.y);
        pz = longint'(p.z);
        turn_plane(py, pz, angle_x_now);
        turn_plane(pz, px, angle_y_now);
        turn_plane(px, py, angle_z_now);
        r.x = t_coord'(px);
        r.y = t_coord'(py);
        r.z = t_coord'(pz);
        return r;
    endfunction

    // Sample handshakes, track angle writes, check results and queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_beat  <= 1'b0;
            cfg_beat <= 1'b0;
        end else begin
            pt_beat  <= pt_in.valid && pt_in.ready;
            cfg_beat <= angle_cfg.valid && angle_cfg.ready;
            if (angle_cfg.valid && angle_cfg.ready) begin
                case (angle_cfg.index)
                    CFG_ANGLE_X: angle_x_now = angle_cfg.wdata;
                    CFG_ANGLE_Y: angle_y_now = angle_cfg.wdata;
                    CFG_ANGLE_Z: angle_z_now = angle_cfg.wdata;
                    default: ;
                endcase
            end
            if (pt_out.valid && pt_out.ready) begin
                if (rotated_points.size() == 0) begin
                    $error("output beat with no point in flight: %0d %0d %0d",
                           pt_out.x_out, pt_out.y_out, pt_out.z_out);
                    failures++;
                end else begin
                    xyz_point_t want;
                    want = rotated_points.pop_front();
                    points_checked++;
                    if (pt_out.x_out !== want.x) begin
                        $error("x_out mismatch: expected %0d, got %0d", want.x, pt_out.x_out);
                        failures++;
                    end
                    if (pt_out.y_out !== want.y) begin
                        $error("y_out mismatch: expected %0d, got %0d", want.y, pt_out.y_out);
                        failures++;
                    end
                    if (pt_out.z_out !== want.z) begin
                        $error("z_out mismatch: expected %0d, got %0d", want.z, pt_out.z_out);
                        failures++;
                    end
                    if (want.x == COORD_MAX || want.x == COORD_MIN || want.y == COORD_MAX ||
                        want.y == COORD_MIN || want.z == COORD_MAX || want.z == COORD_MIN) begin
                        clamped_results++;
                    end
                end
            end
            if (pt_in.valid && pt_in.ready) begin
                rotated_points.push_back(predict_rotation('{pt_in.x_in, pt_in.y_in, pt_in.z_in}));
            end
        end
    end

    // Point driver: offer queued points in bursts, with random gaps between bursts
    always @(negedge i_clk) begin
        if (pt_beat) begin
            offer_live = 1'b0;
        end
        if (i_rst_n && !offer_live) begin
            if (gap_left > 0) begin
                gap_left--;
                pt_in.valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                next_point = pending_points.pop_front();
                pt_in.x_in  <= next_point.x;
                pt_in.y_in  <= next_point.y;
                pt_in.z_in  <= next_point.z;
                pt_in.valid <= 1'b1;
                offer_live = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, max_burst);
                    gap_left   = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                end
            end else begin
                pt_in.valid <= 1'b0;
            end
        end
    end

    // Result receiver: rotate the stall pattern, or hold off for a long stretch on request
    always @(negedge i_clk) begin
        if (stall_served != stall_requested) begin
            stall_served = stall_requested;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pt_out.ready <= 1'b0;
        end else begin
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            pt_out.ready <= ready_pattern[0];
        end
    end

    // Hold until every queued point has come back checked, then let the pipe settle
    task automatic wait_drained();
        while (points_checked != points_queued) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_angle(input t_cfg_idx idx, input t_angle value);
        @(negedge i_clk);
        angle_cfg.valid <= 1'b1;
        angle_cfg.index <= idx;
        angle_cfg.wdata <= value;
        do @(negedge i_clk); while (!cfg_beat);
        angle_cfg.valid <= 1'b0;
        angle_writes++;
    endtask

    task automatic set_angles(input int ax, input int ay, input int az);
        wait_drained();
        write_angle(CFG_ANGLE_X, t_angle'(ax));
        write_angle(CFG_ANGLE_Y, t_angle'(ay));
        write_angle(CFG_ANGLE_Z, t_angle'(az));
    endtask

    task automatic queue_point(input t_coord x, input t_coord y, input t_coord z);
        pending_points.push_back('{x, y, z});
        points_queued++;
    endtask

    // Pick sender burst/gap limits and a receiver stall pattern for the next phase
    task automatic set_traffic();
        @(posedge i_clk);
        case ($urandom_range(0, 2))
            0: max_gap = 0;
            1: max_gap = 3;
            default: max_gap = 10;
        endcase
        max_burst = $urandom_range(0, 1) ? 4 : 30;
        case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom) | 16'($urandom);
            2: ready_pattern = 16'($urandom) | 16'h0001;
            default: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
        endcase
    endtask

    function automatic t_angle pick_angle();
        case ($urandom_range(0, 9))
            0: return t_angle'(0);
            1: return t_angle'(DEG_PER_TURN - 1);
            2: return t_angle'($urandom_range(DEG_PER_TURN, (1 << ANGLE_WIDTH) - 1));
            3: return t_angle'(45 * $urandom_range(0, 7));
            default: return t_angle'($urandom_range(0, DEG_PER_TURN - 1));
        endcase
    endfunction

    // Mix full-range, small and near-corner coordinates
    function automatic t_coord pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return t_coord'(COORD_MAX - t_coord'($urandom_range(0, 1 << 16)));
            3: return t_coord'(COORD_MIN + t_coord'($urandom_range(0, 1 << 16)));
            4, 5: return t_coord'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Stop a hung run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("euler_xyz_point_rotator regression: fail");
        $finish;
    end

    initial begin : stimulus
        int n_first;
        i_rst_n         = 1'b0;
        pt_in.valid     = 1'b0;
        pt_in.x_in      = '0;
        pt_in.y_in      = '0;
        pt_in.z_in      = '0;
        pt_out.ready    = 1'b0;
        angle_cfg.valid = 1'b0;
        angle_cfg.index = CFG_ANGLE_X;
        angle_cfg.wdata = '0;
        angle_x_now     = '0;
        angle_y_now     = '0;
        angle_z_now     = '0;
        max_gap         = 3;
        max_burst       = 30;
        ready_pattern   = 16'hB7DF;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            sine_table[d] = quarter_sine_q(d);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset angles: every stage passes through
        queue_point('0, '0, '0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point(COORD_MAX, COORD_MIN, t_coord'(1));
        queue_point(t_coord'(-1), t_coord'(4096), t_coord'(-4096));

        // 45 degrees everywhere: corners must saturate
        set_angles(45, 45, 45);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point(t_coord'(4096), '0, '0);

        // Quadrant boundaries of the sine fold
        set_angles(90, 180, 270);
        queue_point(t_coord'(4096), t_coord'(8192), t_coord'(-12288));
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX);
        queue_point(t_coord'(1), t_coord'(-1), t_coord'(1));

        // Top of range, out-of-turn angles, and a write to the spare index
        set_angles(359, (1 << ANGLE_WIDTH) - 1, DEG_PER_TURN);
        write_angle(CFG_SPARE_INDEX, t_angle'(77));
        queue_point(COORD_MAX, '0, COORD_MIN);
        queue_point(t_coord'(12345), t_coord'(-54321), t_coord'(777));

        set_angles(1, 0, 0);
        queue_point('0, COORD_MAX, COORD_MIN);
        set_angles(30, 135, 225);
        queue_point(t_coord'(40960), t_coord'(-20480), t_coord'(8191));
        queue_point(COORD_MIN, t_coord'(1), COORD_MAX);

        // Random phases: new angles and traffic each time
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_angles(pick_angle(), pick_angle(), pick_angle());
            if ($urandom_range(0, 3) == 0) begin
                write_angle(CFG_SPARE_INDEX, t_angle'($urandom));
            end
            set_traffic();
            n_first = $urandom_range(10, POINTS_PER_PHASE - 10);
            for (int i = 0; i < n_first; i++) begin
                queue_point(pick_coord(), pick_coord(), pick_coord());
            end
            // Stall the output while points keep coming, so the input backs up
            if (p == 1 || $urandom_range(0, 4) == 0) begin
                @(posedge i_clk);
                stall_requested++;
            end
            // Let the pipe empty completely before the rest of the phase
            if (p == 2 || $urandom_range(0, 4) == 0) begin
                wait_drained();
            end
            for (int i = n_first; i < POINTS_PER_PHASE; i++) begin
                queue_point(pick_coord(), pick_coord(), pick_coord());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (rotated_points.size() != 0) begin
            $error("%0d rotated points never came out", rotated_points.size());
            failures++;
        end
        $display("Checked %0d rotated points over %0d angle writes and %0d random phases.",
                 points_checked, angle_writes, RANDOM_PHASES);
        $display("%0d results hit the coordinate limits; %0d mismatches.",
                 clamped_results, failures);
        if (failures == 0) begin
            $display("euler_xyz_point_rotator regression: pass");
        end else begin
            $display("euler_xyz_point_rotator regression: fail");
        end
        $finish;
    end

endmodule

// ----- euler_xyz_point_rotator.f -----
+incdir+src
src/eulr_pkg.sv
src/eulr_if.sv
src/eulr_trig.sv
src/eulr_plane_rot.sv
src/euler_xyz_point_rotator.sv
src/eulr_checker.sv
sim/euler_xyz_point_rotator_test.sv
